// ===== rtl/tmtb_pkg.sv =====
// ----------------------------------------------------------------------------
// tmtb_pkg
// Shared types and constants of the tempo map tick/beat converter.
// ----------------------------------------------------------------------------
package tmtb_pkg;

   typedef enum logic [1:0] {
      CMD_ADD  = 2'd0,
      CMD_T2B  = 2'd1,
      CMD_B2T  = 2'd2,
      CMD_DOWN = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      RD_MID  = 2'd0,
      RD_SEG  = 2'd1,
      RD_SEG1 = 2'd2,
      RD_IDX  = 2'd3
   } rd_sel_type;

   // controller to datapath
   typedef struct packed {
      logic       load_req;
      logic       do_add;
      logic       lat_down;
      logic       srch_init;
      logic       srch_step;
      logic       set_seg;
      logic       lat_t0;
      logic       lat_t1;
      logic       ar_init;
      logic       ar_step;
      logic       load_rsp;
      rd_sel_type rd_sel;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      cmd_type cmd;
      logic    small_tab;
      logic    srch_go;
      logic    ar_last;
   } sts_type;

   localparam int          TICKS_PER_BEAT = 480;
   localparam int          BEATS_PER_BAR  = 4;
   localparam logic [5:0]  DIV_STEPS      = 6'd49;
   localparam logic [5:0]  MUL_STEPS      = 6'd32;

endpackage

// ===== rtl/tmtb_ram.sv =====
// ----------------------------------------------------------------------------
// tmtb_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tmtb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/tmtb_dp.sv =====
// ----------------------------------------------------------------------------
// tmtb_dp
// Datapath: beat table memories, search bounds, serial divider and
// multiplier, result register.
// ----------------------------------------------------------------------------
module tmtb_dp import tmtb_pkg::*; #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  ctl_type            ctl,
   output sts_type            sts,
   input  logic [1:0]         req_command,
   input  logic signed [31:0] req_tick_in,
   input  logic [7:0]         req_beat_level,
   input  logic signed [31:0] req_beat_position,
   input  logic [15:0]        req_beat_index,
   output logic               rsp_accepted,
   output logic signed [31:0] rsp_beat_out,
   output logic signed [47:0] rsp_tick_out,
   output logic               rsp_is_downbeat
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   localparam logic signed [50:0] B_MAX = 51'sd2147483647;
   localparam logic signed [50:0] B_MIN = -51'sd2147483648;
   localparam logic signed [52:0] T_MAX = 53'sd140737488355327;
   localparam logic signed [52:0] T_MIN = -53'sd140737488355328;
   localparam logic [65:0]        P_LIM = 66'd1 << 50;

   // request copy
   cmd_type            cmd_ff, cmd_in;
   logic signed [31:0] tick_ff, tick_in;
   logic signed [31:0] pos_ff, pos_in;
   logic [7:0]         level_ff, level_in;
   logic [15:0]        idx_ff, idx_in;

   // table state
   logic [CW-1:0]      count_ff, count_in;
   logic signed [31:0] last_ff, last_in;

   // per-item work registers
   logic               acc_ff, acc_in;
   logic               down_ff, down_in;
   logic [CW-1:0]      lo_ff, lo_in, hi_ff, hi_in;
   logic [AW-1:0]      seg_ff, seg_in;
   logic signed [31:0] t0_ff, t0_in, t1_ff, t1_in;
   logic               neg_ff, neg_in;
   logic [48:0]        num_ff, num_in;
   logic [31:0]        rem_ff, rem_in;
   logic [31:0]        den_ff, den_in;
   logic [33:0]        mcand_ff, mcand_in;
   logic [65:0]        macc_ff, macc_in;
   logic [5:0]         iter_ff, iter_in;

   // result register
   logic               racc_ff, racc_in;
   logic signed [31:0] rbeat_ff, rbeat_in;
   logic signed [47:0] rtick_ff, rtick_in;
   logic               rdown_ff, rdown_in;

   // memory ports
   logic               add_ok;
   logic               wr_en;
   logic [AW-1:0]      rd_addr;
   logic [31:0]        tick_rd;
   logic [7:0]         level_rd;

   logic [CW:0]        mid_sum;
   logic [CW-1:0]      mid;
   logic [CW-1:0]      nm2;
   logic               small_tab;
   logic [CW-1:0]      seg_lo;
   logic [31:0]        pos_hi;
   logic [47:0]        seg_lim;
   logic               pos_gt;

   logic signed [31:0] tbase;
   logic signed [32:0] diff33, den33;
   logic [32:0]        absdiff;
   logic signed [33:0] a34;
   logic [33:0]        mag34;
   logic [32:0]        rs, rs_sub;
   logic               ge;

   logic signed [50:0] q51, qs, segterm, bsum;
   logic [50:0]        pmag;
   logic signed [51:0] p52;
   logic signed [52:0] tsum;
   logic signed [47:0] small_tick;

   assign small_tab = count_ff < CW'(2);
   assign nm2       = count_ff - CW'(2);
   assign add_ok    = (count_ff < CW'(TABLE_DEPTH)) &&
                      ((count_ff == '0) || (last_ff < tick_ff));
   assign wr_en     = ctl.do_add && add_ok;

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[CW:1];

   always_comb begin
      case (ctl.rd_sel)
         RD_MID:  rd_addr = mid[AW-1:0];
         RD_SEG:  rd_addr = seg_ff;
         RD_SEG1: rd_addr = seg_ff + AW'(1);
         RD_IDX:  rd_addr = idx_ff[AW-1:0];
         default: rd_addr = seg_ff;
      endcase
   end

   tmtb_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_tick_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (tick_ff),
      .rd_addr (rd_addr),
      .rd_data (tick_rd)
   );

   tmtb_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_level_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (level_ff),
      .rd_addr (rd_addr),
      .rd_data (level_rd)
   );

   // segment from the search result, clamped to the first and last segment
   always_comb begin
      if (lo_ff == '0) begin
         seg_lo = '0;
      end else if (lo_ff == count_ff) begin
         seg_lo = nm2;
      end else begin
         seg_lo = lo_ff - CW'(1);
      end
   end

   assign pos_hi  = {16'h0, pos_ff[31:16]};
   assign seg_lim = {{(32 - CW){1'b0}}, nm2, 16'h0};
   assign pos_gt  = {16'h0, pos_ff} > seg_lim;

   // operand setup
   assign tbase   = small_tab ? 32'sd0 : t0_ff;
   assign diff33  = {tick_ff[31], tick_ff} - {tbase[31], tbase};
   assign den33   = {t1_ff[31], t1_ff} - {t0_ff[31], t0_ff};
   assign absdiff = diff33[32] ? 33'(-diff33) : 33'(diff33);
   assign a34     = {{2{pos_ff[31]}}, pos_ff} - $signed({{(18 - AW){1'b0}}, seg_ff, 16'h0});
   assign mag34   = a34[33] ? 34'(-a34) : 34'(a34);

   // restoring divide step
   assign rs     = {rem_ff, num_ff[48]};
   assign ge     = rs >= {1'b0, den_ff};
   assign rs_sub = rs - {1'b0, den_ff};

   // final tick to beat: floor quotient plus the segment's whole beats
   assign q51     = $signed({2'b00, num_ff});
   assign qs      = neg_ff ? ((rem_ff != '0) ? ~q51 : -q51) : q51;
   assign segterm = small_tab ? 51'sd0 : $signed({{(35 - AW){1'b0}}, seg_ff, 16'h0});
   assign bsum    = qs + segterm;

   // final beat to tick
   assign pmag       = (macc_ff > P_LIM) ? P_LIM[50:0] : macc_ff[50:0];
   assign p52        = neg_ff ? -$signed({1'b0, pmag}) : $signed({1'b0, pmag});
   assign tsum       = {p52[51], p52} + $signed({{5{t0_ff[31]}}, t0_ff, 16'h0});
   assign small_tick = $signed({{16{pos_ff[31]}}, pos_ff}) * 48'sd480;

   always_comb begin
      cmd_in   = cmd_ff;
      tick_in  = tick_ff;
      pos_in   = pos_ff;
      level_in = level_ff;
      idx_in   = idx_ff;
      count_in = count_ff;
      last_in  = last_ff;
      acc_in   = acc_ff;
      down_in  = down_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      seg_in   = seg_ff;
      t0_in    = t0_ff;
      t1_in    = t1_ff;
      neg_in   = neg_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      mcand_in = mcand_ff;
      macc_in  = macc_ff;
      iter_in  = iter_ff;
      racc_in  = racc_ff;
      rbeat_in = rbeat_ff;
      rtick_in = rtick_ff;
      rdown_in = rdown_ff;

      if (ctl.load_req) begin
         cmd_in   = cmd_type'(req_command);
         tick_in  = req_tick_in;
         pos_in   = req_beat_position;
         level_in = req_beat_level;
         idx_in   = req_beat_index;
      end

      if (ctl.do_add) begin
         acc_in = add_ok;
         if (add_ok) begin
            count_in = count_ff + CW'(1);
            last_in  = tick_ff;
         end
      end

      if (ctl.lat_down) begin
         if (count_ff == '0) begin
            down_in = (idx_ff % 16'(BEATS_PER_BAR)) == 16'd0;
         end else begin
            down_in = ({1'b0, idx_ff} < 17'(count_ff)) && (level_rd != 8'd0);
         end
      end

      if (ctl.srch_init) begin
         lo_in = '0;
         hi_in = count_ff;
      end
      if (ctl.srch_step) begin
         if ($signed(tick_rd) < tick_ff) begin
            lo_in = mid + CW'(1);
         end else begin
            hi_in = mid;
         end
      end

      if (ctl.set_seg) begin
         if (cmd_ff == CMD_T2B) begin
            seg_in = seg_lo[AW-1:0];
         end else if (pos_ff[31]) begin
            seg_in = '0;
         end else if (pos_gt) begin
            seg_in = nm2[AW-1:0];
         end else begin
            seg_in = pos_hi[AW-1:0];
         end
      end

      if (ctl.lat_t0) begin
         t0_in = $signed(tick_rd);
      end
      if (ctl.lat_t1) begin
         t1_in = $signed(tick_rd);
      end

      if (ctl.ar_init) begin
         rem_in  = '0;
         macc_in = '0;
         if (cmd_ff == CMD_T2B) begin
            iter_in = DIV_STEPS;
            neg_in  = diff33[32];
            num_in  = {absdiff, 16'h0};
            den_in  = small_tab ? 32'(TICKS_PER_BEAT) : den33[31:0];
         end else begin
            iter_in  = MUL_STEPS;
            neg_in   = a34[33];
            mcand_in = mag34;
            den_in   = den33[31:0];
         end
      end

      if (ctl.ar_step) begin
         iter_in = iter_ff - 6'd1;
         if (cmd_ff == CMD_T2B) begin
            rem_in = ge ? rs_sub[31:0] : rs[31:0];
            num_in = {num_ff[47:0], ge};
         end else begin
            macc_in = {macc_ff[64:0], 1'b0} + (den_ff[31] ? {32'h0, mcand_ff} : 66'h0);
            den_in  = {den_ff[30:0], 1'b0};
         end
      end

      if (ctl.load_rsp) begin
         racc_in  = (cmd_ff == CMD_ADD) && acc_ff;
         rdown_in = (cmd_ff == CMD_DOWN) && down_ff;
         rbeat_in = '0;
         rtick_in = '0;
         if (cmd_ff == CMD_T2B) begin
            if (bsum > B_MAX) begin
               rbeat_in = 32'sh7FFFFFFF;
            end else if (bsum < B_MIN) begin
               rbeat_in = 32'sh80000000;
            end else begin
               rbeat_in = bsum[31:0];
            end
         end
         if (cmd_ff == CMD_B2T) begin
            if (small_tab) begin
               rtick_in = small_tick;
            end else if (tsum > T_MAX) begin
               rtick_in = T_MAX[47:0];
            end else if (tsum < T_MIN) begin
               rtick_in = T_MIN[47:0];
            end else begin
               rtick_in = tsum[47:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      cmd_ff   <= cmd_in;
      tick_ff  <= tick_in;
      pos_ff   <= pos_in;
      level_ff <= level_in;
      idx_ff   <= idx_in;
      last_ff  <= last_in;
      acc_ff   <= acc_in;
      down_ff  <= down_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      seg_ff   <= seg_in;
      t0_ff    <= t0_in;
      t1_ff    <= t1_in;
      neg_ff   <= neg_in;
      num_ff   <= num_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      mcand_ff <= mcand_in;
      macc_ff  <= macc_in;
      iter_ff  <= iter_in;
      racc_ff  <= racc_in;
      rbeat_ff <= rbeat_in;
      rtick_ff <= rtick_in;
      rdown_ff <= rdown_in;
   end

   assign sts.cmd       = cmd_ff;
   assign sts.small_tab = small_tab;
   assign sts.srch_go   = lo_ff < hi_ff;
   assign sts.ar_last   = iter_ff == 6'd1;

   assign rsp_accepted    = racc_ff;
   assign rsp_beat_out    = rbeat_ff;
   assign rsp_tick_out    = rtick_ff;
   assign rsp_is_downbeat = rdown_ff;

endmodule

// ===== rtl/tmtb_ctrl.sv =====
// ----------------------------------------------------------------------------
// tmtb_ctrl
// Controller: sequences table access, search and arithmetic per command and
// owns both handshakes.
// ----------------------------------------------------------------------------
module tmtb_ctrl import tmtb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output ctl_type ctl
);

   typedef enum logic [15:0] {
      S_IDLE  = 16'h0001,
      S_DISP  = 16'h0002,
      S_ADD   = 16'h0004,
      S_LVL   = 16'h0008,
      S_LVLW  = 16'h0010,
      S_SINIT = 16'h0020,
      S_SRD   = 16'h0040,
      S_SCMP  = 16'h0080,
      S_BSEG  = 16'h0100,
      S_T0    = 16'h0200,
      S_T1    = 16'h0400,
      S_T1W   = 16'h0800,
      S_SETUP = 16'h1000,
      S_DIV   = 16'h2000,
      S_MUL   = 16'h4000,
      S_FIN   = 16'h8000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      ctl.rd_sel = RD_SEG;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.load_req = 1'b1;
               state_in     = S_DISP;
            end
         end
         S_DISP: begin
            case (sts.cmd)
               CMD_ADD:  state_in = S_ADD;
               CMD_T2B:  state_in = sts.small_tab ? S_SETUP : S_SINIT;
               CMD_B2T:  state_in = sts.small_tab ? S_FIN : S_BSEG;
               default:  state_in = S_LVL;
            endcase
         end
         S_ADD: begin
            ctl.do_add = 1'b1;
            state_in   = S_FIN;
         end
         S_LVL: begin
            ctl.rd_sel = RD_IDX;
            state_in   = S_LVLW;
         end
         S_LVLW: begin
            ctl.lat_down = 1'b1;
            state_in     = S_FIN;
         end
         S_SINIT: begin
            ctl.srch_init = 1'b1;
            state_in      = S_SRD;
         end
         S_SRD: begin
            if (sts.srch_go) begin
               ctl.rd_sel = RD_MID;
               state_in   = S_SCMP;
            end else begin
               ctl.set_seg = 1'b1;
               state_in    = S_T0;
            end
         end
         S_SCMP: begin
            ctl.rd_sel    = RD_MID;
            ctl.srch_step = 1'b1;
            state_in      = S_SRD;
         end
         S_BSEG: begin
            ctl.set_seg = 1'b1;
            state_in    = S_T0;
         end
         S_T0: begin
            ctl.rd_sel = RD_SEG;
            state_in   = S_T1;
         end
         S_T1: begin
            ctl.rd_sel = RD_SEG1;
            ctl.lat_t0 = 1'b1;
            state_in   = S_T1W;
         end
         S_T1W: begin
            ctl.lat_t1 = 1'b1;
            state_in   = S_SETUP;
         end
         S_SETUP: begin
            ctl.ar_init = 1'b1;
            state_in    = (sts.cmd == CMD_T2B) ? S_DIV : S_MUL;
         end
         S_DIV, S_MUL: begin
            ctl.ar_step = 1'b1;
            if (sts.ar_last) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               ctl.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (ctl.load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/tempo_map_tick_beat_converter.sv =====
// ----------------------------------------------------------------------------
// tempo_map_tick_beat_converter
// Piecewise linear tempo map: beat table with tick/beat conversion.
//
//   channel  direction  ports
//   req      in         req_valid, req_stall, req_command, req_tick_in,
//                       req_beat_level, req_beat_position, req_beat_index
//   rsp      out        rsp_valid, rsp_stall, rsp_accepted, rsp_beat_out,
//                       rsp_tick_out, rsp_is_downbeat
//
// one item at a time. beat to tick on a table under two beats skips the
// table reads and the multiplier; tick to beat on a small table skips the
// search and table reads. the divider and multiplier work one bit per
// cycle, and the binary search uses the table memory's single read port.
// reset clears the beat count and the controller; table contents are not
// cleared. a finished result waits in the output register while rsp_stall
// is high; the next item is taken meanwhile and held before its result.
// ----------------------------------------------------------------------------
module tempo_map_tick_beat_converter import tmtb_pkg::*; #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_command,
   input  logic signed [31:0] req_tick_in,
   input  logic [7:0]         req_beat_level,
   input  logic signed [31:0] req_beat_position,
   input  logic [15:0]        req_beat_index,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_accepted,
   output logic signed [31:0] rsp_beat_out,
   output logic signed [47:0] rsp_tick_out,
   output logic               rsp_is_downbeat
);

   ctl_type ctl;
   sts_type sts;

   tmtb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   tmtb_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .sts               (sts),
      .req_command       (req_command),
      .req_tick_in       (req_tick_in),
      .req_beat_level    (req_beat_level),
      .req_beat_position (req_beat_position),
      .req_beat_index    (req_beat_index),
      .rsp_accepted      (rsp_accepted),
      .rsp_beat_out      (rsp_beat_out),
      .rsp_tick_out      (rsp_tick_out),
      .rsp_is_downbeat   (rsp_is_downbeat)
   );

endmodule
